// File: hdl/bpc_pkg.sv
// Package for the binary partition counter.
// Holds the fixed field widths and the sequencer state type; depends on nothing.
package bpc_pkg;

    localparam int TARGET_W = 12;
    localparam int WAYS_W   = 64;

    typedef logic [TARGET_W-1:0] target_t;
    typedef logic [WAYS_W-1:0]   ways_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_FETCH,
        ST_DONE
    } bpc_state_t;

endpackage

// File: hdl/bpc_stream_if.sv
// Valid/ready channel interfaces for the binary partition counter.
// Depends on bpc_pkg for the payload types.
interface bpc_in_if;
    import bpc_pkg::*;

    logic    valid;
    logic    ready;
    target_t target;

    modport source (output valid, output target, input ready);
    modport sink   (input valid, input target, output ready);
endinterface

interface bpc_out_if;
    import bpc_pkg::*;

    logic  valid;
    logic  ready;
    ways_t ways;
    logic  overflow;

    modport source (output valid, output ways, output overflow, input ready);
    modport sink   (input valid, input ways, input overflow, output ready);
endinterface

// File: hdl/binary_partition_counter_top.sv
// Binary partition counter: counts the ways a target is a sum of powers of two.
// Depends on bpc_pkg and the channel interfaces in bpc_stream_if.sv.
//
// One request carries a target n (clamped to MAX_TARGET) and yields one result:
// the number of binary partitions of n, saturated at 2^64-1, with a flag that is
// set if any partial count saturated. The counts live in one memory of
// MAX_TARGET+1 words of 64 bits with a registered read. The block works on one
// request at a time: a fill pass, then one update pass per coin c = 2, 4, 8, ...
// not above n, then a fetch of entry n. Each update is a read step followed by a
// write step through the memory's single write port.
// The first pass sets entries 0 to n to one, so no clearing pass is needed. A
// finished result waits in an output register, and the next request is taken
// while it waits.
module binary_partition_counter_top #(
    parameter int MAX_TARGET = 4095
) (
    input  logic       clk,
    input  logic       rst_n,
    bpc_in_if.sink     request,
    bpc_out_if.source  result
);
    import bpc_pkg::*;

    localparam int DEPTH = MAX_TARGET + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    typedef logic [AW-1:0] addr_t;
    typedef logic [AW:0]   coin_t;

    bpc_state_t state_reg, state_next;
    addr_t      n_reg, n_next;
    addr_t      i_reg, i_next;
    coin_t      coin_reg, coin_next;
    logic       sat_reg, sat_next;

    logic       out_valid_reg, out_valid_next;
    ways_t      ways_reg, ways_next;
    logic       ovf_reg, ovf_next;

    // Memory of partial counts.
    ways_t      mem [DEPTH];
    ways_t      rda_reg, rdb_reg;
    logic       we;
    addr_t      wa, ra, rb;
    ways_t      wd;

    logic       accept;
    logic       load_out;
    addr_t      n_clamped;
    logic [WAYS_W:0] sum;
    coin_t      coin_dbl;
    coin_t      coin_two;

    assign accept   = request.valid && request.ready;
    assign coin_two = (AW+1)'(2);
    assign coin_dbl = {coin_reg[AW-1:0], 1'b0};
    assign sum      = {1'b0, rda_reg} + {1'b0, rdb_reg};

    always_comb
    begin
        if (32'(request.target) > 32'(MAX_TARGET))
        begin
            n_clamped = AW'(MAX_TARGET);
        end
        else
        begin
            n_clamped = AW'(request.target);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (i_reg == n_reg)
                begin
                    if (coin_two <= {1'b0, n_reg})
                    begin
                        state_next = ST_UPD_RD;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                if (i_reg == n_reg && coin_dbl > {1'b0, n_reg})
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        n_next    = n_reg;
        i_next    = i_reg;
        coin_next = coin_reg;
        sat_next  = sat_reg;
        we        = 1'b0;
        wa        = i_reg;
        wd        = WAYS_W'(1);
        ra        = i_reg;
        rb        = i_reg - coin_reg[AW-1:0];
        load_out  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next    = n_clamped;
                    i_next    = '0;
                    coin_next = (AW+1)'(1);
                    sat_next  = 1'b0;
                end
            end
            ST_FILL:
            begin
                // With only the unit coin every count is one.
                we = 1'b1;
                if (i_reg == n_reg)
                begin
                    coin_next = coin_two;
                    i_next    = coin_two[AW-1:0];
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_UPD_RD:
            begin
            end
            ST_UPD_WR:
            begin
                we = 1'b1;
                if (sum[WAYS_W])
                begin
                    wd       = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    wd = sum[WAYS_W-1:0];
                end
                if (i_reg == n_reg)
                begin
                    coin_next = coin_dbl;
                    i_next    = coin_dbl[AW-1:0];
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_FETCH:
            begin
                ra = n_reg;
            end
            ST_DONE:
            begin
                ra       = n_reg;
                load_out = !out_valid_reg || result.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ways_next = ways_reg;
        ovf_next  = ovf_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            ways_next      = rda_reg;
            ovf_next       = sat_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rda_reg <= mem[ra];
        rdb_reg <= mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        coin_reg <= coin_next;
        sat_reg  <= sat_next;
        ways_reg <= ways_next;
        ovf_reg  <= ovf_next;
    end

    assign request.ready   = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.ways     = ways_reg;
    assign result.overflow = ovf_reg;

endmodule
